### design/olt_pkg.sv
// Shared types and codes for the ordered list table.
// No dependencies; compile first.
package olt_pkg;

  localparam int CAPACITY_DEF    = 128;
  localparam int VALUE_WIDTH_DEF = 32;

  // request opcodes
  localparam logic [2:0] CMD_APPEND = 3'd0;
  localparam logic [2:0] CMD_INSERT = 3'd1;
  localparam logic [2:0] CMD_REMOVE = 3'd2;
  localparam logic [2:0] CMD_FIND   = 3'd3;
  localparam logic [2:0] CMD_GET    = 3'd4;
  localparam logic [2:0] CMD_SET    = 3'd5;

  // result status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BADPOS   = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;
  localparam logic [1:0] ST_NOTFOUND = 2'd3;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [7:0]  position;
    logic [31:0] value;
  } olt_req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [6:0]  found_position;
    logic [31:0] read_value;
    logic [7:0]  count_now;
  } olt_rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SHIFT_UP,
    ST_PUT,
    ST_SHIFT_DOWN,
    ST_SEARCH,
    ST_GET_WAIT
  } olt_state_t;

endpackage

### design/olt_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module olt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### design/ordered_list_table_top.sv
// Ordered list table: list of values in one RAM plus an entry count.
// Depends on olt_pkg and olt_ram.
//
// Usage:
//   A request beat (cmd, position, value) is taken at a rising edge where
//   start is high and busy is low. Exactly one result beat follows: done is
//   high for one cycle with status, found_position, read_value and count_now
//   on result. The receiver cannot stall; results are never held.
// Work per request:
//   append, set, bad position, full, unused codes: answered without a RAM read
//   get: one RAM read, its registered data returned as read_value
//   insert at position p of n entries: entries n-1 down to p move up one slot,
//   then the value is written at p (an append when p equals n)
//   remove at p: entries p+1 to n-1 move down one slot (none when p is last)
//   find: one RAM read per entry walked, from entry 0 to a hit or the last entry
//   The longest request is an insert at the head of CAPACITY-1 entries; its
//   length is set by the RAM's single read and write port, one entry per cycle.
// A new request may start in the cycle its predecessor's result is shown.
// Reset clears the count and the controller only; RAM contents stay
// undefined, and every read is kept below the count, so no clearing pass.
module ordered_list_table_top #(
  parameter int CAPACITY    = olt_pkg::CAPACITY_DEF,
  parameter int VALUE_WIDTH = olt_pkg::VALUE_WIDTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  olt_pkg::olt_req_t request,
  output logic              done,
  output olt_pkg::olt_rsp_t result
);
  import olt_pkg::*;

  localparam int AW = $clog2(CAPACITY);      // RAM address bits
  localparam int CW = $clog2(CAPACITY + 1);  // count bits, holds CAPACITY
  localparam int PW = (CW > 8) ? CW : 8;     // common width for compares

  // --- registers ---
  olt_state_t             state, state_next;
  logic [CW-1:0]          count, count_next;
  logic [AW-1:0]          rd_ptr, rd_ptr_next;   // address of the read in flight
  logic [AW-1:0]          pos_r;                 // insert target
  logic [VALUE_WIDTH-1:0] val_r;                 // masked request value
  logic                   done_next;
  olt_rsp_t               rsp_next;

  // --- RAM port ---
  logic                   mem_we;
  logic [AW-1:0]          mem_waddr, mem_raddr;
  logic [VALUE_WIDTH-1:0] mem_wdata, mem_rdata;

  olt_ram #(
    .WIDTH (VALUE_WIDTH),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // --- decode ---
  logic                   accept;
  logic [63:0]            val64, rd64;
  logic [VALUE_WIDTH-1:0] val_w;
  logic [PW-1:0]          pos_ext, pos_inc_ext, cnt_ext, last_ext, ptr_ext, cnt_next_ext;
  logic                   is_full, pos_lt_cnt, pos_le_cnt, pos_is_last;
  logic                   at_last, at_pos, hit;
  logic [AW-1:0]          ptr_inc, ptr_dec;

  assign busy   = (state != ST_IDLE);
  assign accept = start && !busy;

  // value masked to the stored width (upper bits zero above 32)
  assign val64  = {32'd0, request.value};
  assign val_w  = val64[VALUE_WIDTH-1:0];
  assign rd64   = 64'(mem_rdata);

  assign pos_ext      = PW'(request.position);
  assign pos_inc_ext  = pos_ext + PW'(1);
  assign cnt_ext      = PW'(count);
  assign last_ext     = cnt_ext - PW'(1);
  assign ptr_ext      = PW'(rd_ptr);
  assign cnt_next_ext = PW'(count_next);

  assign is_full     = (count == CW'(CAPACITY));
  assign pos_lt_cnt  = (pos_ext < cnt_ext);
  assign pos_le_cnt  = (pos_ext <= cnt_ext);
  assign pos_is_last = (pos_ext == last_ext);

  assign at_last = (ptr_ext == last_ext);
  assign at_pos  = (rd_ptr == pos_r);
  assign hit     = (mem_rdata == val_r);
  assign ptr_inc = rd_ptr + AW'(1);
  assign ptr_dec = rd_ptr - AW'(1);

  // --- next state ---
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          case (request.cmd)
            CMD_INSERT: begin
              if (pos_lt_cnt && !is_full) state_next = ST_SHIFT_UP;
            end
            CMD_REMOVE: begin
              if (pos_lt_cnt && !pos_is_last) state_next = ST_SHIFT_DOWN;
            end
            CMD_FIND: begin
              if (count != '0) state_next = ST_SEARCH;
            end
            CMD_GET: begin
              if (pos_lt_cnt) state_next = ST_GET_WAIT;
            end
            default: state_next = ST_IDLE;
          endcase
        end
      end
      ST_SHIFT_UP:   if (at_pos) state_next = ST_PUT;
      ST_PUT:        state_next = ST_IDLE;
      ST_SHIFT_DOWN: if (at_last) state_next = ST_IDLE;
      ST_SEARCH:     if (hit || at_last) state_next = ST_IDLE;
      ST_GET_WAIT:   state_next = ST_IDLE;
      default:       state_next = ST_IDLE;
    endcase
  end

  // --- datapath and result ---
  always_comb begin
    mem_we      = 1'b0;
    mem_waddr   = pos_ext[AW-1:0];
    mem_wdata   = val_w;
    mem_raddr   = rd_ptr;
    rd_ptr_next = rd_ptr;
    count_next  = count;
    done_next   = 1'b0;
    rsp_next    = '0;
    rsp_next.status = ST_OK;

    case (state)
      ST_IDLE: begin
        if (accept) begin
          case (request.cmd)
            CMD_APPEND: begin
              done_next = 1'b1;
              if (is_full) begin
                rsp_next.status = ST_FULL;
              end else begin
                mem_we     = 1'b1;
                mem_waddr  = cnt_ext[AW-1:0];
                count_next = count + CW'(1);
              end
            end
            CMD_INSERT: begin
              if (!pos_le_cnt) begin
                done_next       = 1'b1;
                rsp_next.status = ST_BADPOS;
              end else if (is_full) begin
                done_next       = 1'b1;
                rsp_next.status = ST_FULL;
              end else if (!pos_lt_cnt) begin
                // insert at the end is an append
                done_next  = 1'b1;
                mem_we     = 1'b1;
                mem_waddr  = cnt_ext[AW-1:0];
                count_next = count + CW'(1);
              end else begin
                mem_raddr   = last_ext[AW-1:0];
                rd_ptr_next = last_ext[AW-1:0];
              end
            end
            CMD_REMOVE: begin
              if (!pos_lt_cnt) begin
                done_next       = 1'b1;
                rsp_next.status = ST_BADPOS;
              end else if (pos_is_last) begin
                done_next  = 1'b1;
                count_next = count - CW'(1);
              end else begin
                mem_raddr   = pos_inc_ext[AW-1:0];
                rd_ptr_next = pos_inc_ext[AW-1:0];
              end
            end
            CMD_FIND: begin
              if (count == '0) begin
                done_next       = 1'b1;
                rsp_next.status = ST_NOTFOUND;
              end else begin
                mem_raddr   = '0;
                rd_ptr_next = '0;
              end
            end
            CMD_GET: begin
              if (!pos_lt_cnt) begin
                done_next       = 1'b1;
                rsp_next.status = ST_BADPOS;
              end else begin
                mem_raddr   = pos_ext[AW-1:0];
                rd_ptr_next = pos_ext[AW-1:0];
              end
            end
            CMD_SET: begin
              done_next = 1'b1;
              if (!pos_lt_cnt) begin
                rsp_next.status = ST_BADPOS;
              end else begin
                mem_we = 1'b1;
              end
            end
            default: done_next = 1'b1;
          endcase
        end
      end
      ST_SHIFT_UP: begin
        // move entry up one slot, walking toward the insert point
        mem_we    = 1'b1;
        mem_waddr = ptr_inc;
        mem_wdata = mem_rdata;
        if (!at_pos) begin
          mem_raddr   = ptr_dec;
          rd_ptr_next = ptr_dec;
        end
      end
      ST_PUT: begin
        mem_we     = 1'b1;
        mem_waddr  = pos_r;
        mem_wdata  = val_r;
        count_next = count + CW'(1);
        done_next  = 1'b1;
      end
      ST_SHIFT_DOWN: begin
        // move entry down one slot, walking toward the tail
        mem_we    = 1'b1;
        mem_waddr = ptr_dec;
        mem_wdata = mem_rdata;
        if (at_last) begin
          count_next = count - CW'(1);
          done_next  = 1'b1;
        end else begin
          mem_raddr   = ptr_inc;
          rd_ptr_next = ptr_inc;
        end
      end
      ST_SEARCH: begin
        if (hit) begin
          done_next               = 1'b1;
          rsp_next.found_position = ptr_ext[6:0];
        end else if (at_last) begin
          done_next       = 1'b1;
          rsp_next.status = ST_NOTFOUND;
        end else begin
          mem_raddr   = ptr_inc;
          rd_ptr_next = ptr_inc;
        end
      end
      ST_GET_WAIT: begin
        done_next           = 1'b1;
        rsp_next.read_value = rd64[31:0];
      end
      default: done_next = 1'b0;
    endcase

    rsp_next.count_now = cnt_next_ext[7:0];
  end

  // --- registers ---
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      done  <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    rd_ptr <= rd_ptr_next;
    result <= rsp_next;
    if (accept) begin
      pos_r <= pos_ext[AW-1:0];
      val_r <= val_w;
    end
  end

endmodule
